FILE: hdl/sva_pkg.sv
package sva_pkg;

	localparam int CB       = 12;
	localparam int AB       = 16;
	localparam int NSQ      = 32;
	localparam int NCR      = 32;
	localparam int XW       = 40;
	localparam int AW       = 36;
	localparam int NORM_TOP = 60;

	localparam logic [AB:0] FULL_TURN = 17'd65536;
	localparam logic [AB:0] HALF_TURN = 17'd32768;

	typedef struct packed {
		logic degen;
		logic colin;
		logic dpos;
		logic cneg;
	} flags_t;

	function automatic logic [31:0] atan_lut(input logic [4:0] i);
		logic [31:0] r;
		case (i)
			5'd0:    r = 32'h20000000;
			5'd1:    r = 32'h12E4051E;
			5'd2:    r = 32'h09FB385B;
			5'd3:    r = 32'h051111D4;
			5'd4:    r = 32'h028B0D43;
			5'd5:    r = 32'h0145D7E1;
			5'd6:    r = 32'h00A2F61E;
			5'd7:    r = 32'h00517C55;
			5'd8:    r = 32'h0028BE53;
			5'd9:    r = 32'h00145F2F;
			5'd10:   r = 32'h000A2F98;
			5'd11:   r = 32'h000517CC;
			5'd12:   r = 32'h00028BE6;
			5'd13:   r = 32'h000145F3;
			5'd14:   r = 32'h0000A2FA;
			5'd15:   r = 32'h0000517D;
			5'd16:   r = 32'h000028BE;
			5'd17:   r = 32'h0000145F;
			5'd18:   r = 32'h00000A30;
			5'd19:   r = 32'h00000518;
			5'd20:   r = 32'h0000028C;
			5'd21:   r = 32'h00000146;
			5'd22:   r = 32'h000000A3;
			5'd23:   r = 32'h00000051;
			5'd24:   r = 32'h00000029;
			5'd25:   r = 32'h00000014;
			5'd26:   r = 32'h0000000A;
			5'd27:   r = 32'h00000005;
			5'd28:   r = 32'h00000003;
			5'd29:   r = 32'h00000001;
			5'd30:   r = 32'h00000001;
			default: r = 32'h00000000;
		endcase
		return r;
	endfunction

	// shift the magnitude, keep the sign
	function automatic logic signed [XW-1:0] shr_sym(input logic signed [XW-1:0] v,
		input logic [4:0] n);
		logic [XW-1:0] m;
		m = v[XW-1] ? (~v + 1'b1) : v;
		m = m >> n;
		return v[XW-1] ? $signed(~m + 1'b1) : $signed(m);
	endfunction

endpackage

FILE: hdl/signed_vector_angle_unit.sv
// channel  dir  tdata (low bit up)                               tuser
// s_       in   a_x,a_y,a_z,b_x,b_y,b_z,n_x,n_y,n_z (12b each)    -
// m_       out  angle_turns (17b), zero pad to 24b               degenerate
//
// One item per cycle sustained while the output item is taken.
// The pipe includes the 32-stage square root and the 32-stage CORDIC.
// arst_n clears only the valid bits of every stage.
// One enable holds the whole pipe while the output item is not taken.
module signed_vector_angle_unit
	import sva_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [111:0] s_tdata,   // a_x,a_y,a_z,b_x,b_y,b_z,n_x,n_y,n_z
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [23:0]  m_tdata,   // angle_turns, zero pad
	output logic [0:0]   m_tuser    // degenerate
);

	logic en;
	logic vout_q;
	assign en = !vout_q || m_tready;
	assign s_tready = en;

	logic signed [CB-1:0] ax, ay, az, bx, by, bz, nx, ny, nz;
	assign ax = s_tdata[11:0];
	assign ay = s_tdata[23:12];
	assign az = s_tdata[35:24];
	assign bx = s_tdata[47:36];
	assign by = s_tdata[59:48];
	assign bz = s_tdata[71:60];
	assign nx = s_tdata[83:72];
	assign ny = s_tdata[95:84];
	assign nz = s_tdata[107:96];

	// stage 1: products
	logic vld_s1;
	logic signed [2*CB-1:0] aa0_s1, aa1_s1, aa2_s1, bb0_s1, bb1_s1, bb2_s1;
	logic signed [2*CB-1:0] c0p_s1, c0m_s1, c1p_s1, c1m_s1, c2p_s1, c2m_s1;
	logic signed [2*CB-1:0] d0_s1, d1_s1, d2_s1;
	logic signed [CB-1:0]   nx_s1, ny_s1, nz_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (en) vld_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			aa0_s1 <= ax * ax; aa1_s1 <= ay * ay; aa2_s1 <= az * az;
			bb0_s1 <= bx * bx; bb1_s1 <= by * by; bb2_s1 <= bz * bz;
			c0p_s1 <= ay * bz; c0m_s1 <= by * az;
			c1p_s1 <= bx * az; c1m_s1 <= ax * bz;
			c2p_s1 <= ax * by; c2m_s1 <= bx * ay;
			d0_s1  <= ax * bx; d1_s1  <= ay * by; d2_s1 <= az * bz;
			nx_s1  <= nx; ny_s1 <= ny; nz_s1 <= nz;
		end
	end

	// stage 2: sums
	logic vld_s2;
	logic [24:0]         na2_s2, nb2_s2;
	logic signed [24:0]  cx_s2, cy_s2, cz_s2, d_s2;
	logic signed [CB-1:0] nx_s2, ny_s2, nz_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else if (en) vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			na2_s2 <= 25'($unsigned(aa0_s1)) + 25'($unsigned(aa1_s1))
				+ 25'($unsigned(aa2_s1));
			nb2_s2 <= 25'($unsigned(bb0_s1)) + 25'($unsigned(bb1_s1))
				+ 25'($unsigned(bb2_s1));
			cx_s2 <= 25'(c0p_s1) - 25'(c0m_s1);
			cy_s2 <= 25'(c1p_s1) - 25'(c1m_s1);
			cz_s2 <= 25'(c2p_s1) - 25'(c2m_s1);
			d_s2  <= 25'(d0_s1) + 25'(d1_s1) + 25'(d2_s1);
			nx_s2 <= nx_s1; ny_s2 <= ny_s1; nz_s2 <= nz_s1;
		end
	end

	// stage 3: squares and normal products
	logic vld_s3;
	logic [47:0]        r2_s3, cxx_s3, cyy_s3, czz_s3;
	logic signed [36:0] pcx_s3, pcy_s3, pcz_s3;
	logic signed [24:0] d_s3;
	flags_t             fl_s3;
	logic [47:0]        r2_w;
	logic signed [47:0] cxx_w, cyy_w, czz_w;
	logic signed [36:0] pcx_w, pcy_w, pcz_w;

	assign r2_w  = 48'(na2_s2) * 48'(nb2_s2);
	assign cxx_w = 48'(cx_s2) * 48'(cx_s2);
	assign cyy_w = 48'(cy_s2) * 48'(cy_s2);
	assign czz_w = 48'(cz_s2) * 48'(cz_s2);
	assign pcx_w = 37'(cx_s2) * 37'(nx_s2);
	assign pcy_w = 37'(cy_s2) * 37'(ny_s2);
	assign pcz_w = 37'(cz_s2) * 37'(nz_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0;
		else if (en) vld_s3 <= vld_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r2_s3  <= r2_w;
			cxx_s3 <= $unsigned(cxx_w);
			cyy_s3 <= $unsigned(cyy_w);
			czz_s3 <= $unsigned(czz_w);
			pcx_s3 <= pcx_w;
			pcy_s3 <= pcy_w;
			pcz_s3 <= pcz_w;
			d_s3   <= d_s2;
			fl_s3.degen <= (na2_s2 == '0) || (nb2_s2 == '0);
			fl_s3.colin <= (cx_s2 == '0) && (cy_s2 == '0) && (cz_s2 == '0);
			fl_s3.dpos  <= (d_s2 > 0);
			fl_s3.cneg  <= 1'b0;
		end
	end

	// stage 4: |c|^2, sign of c.n, normalising shift
	logic vld_s4;
	logic [47:0]        s2_s4;
	logic [4:0]         f_s4;
	logic signed [24:0] d_s4;
	flags_t             fl_s4;
	logic signed [38:0] cn;
	logic [5:0]         msb;

	always_comb begin
		msb = '0;
		for (int i = 0; i < 48; i++)
			if (r2_s3[i]) msb = 6'(i);
		cn = 39'(pcx_s3) + 39'(pcy_s3) + 39'(pcz_s3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s4 <= 1'b0;
		else if (en) vld_s4 <= vld_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s2_s4 <= cxx_s3 + cyy_s3 + czz_s3;
			f_s4  <= 5'((7'(NORM_TOP + 1) - 7'(msb)) >> 1);
			d_s4  <= d_s3;
			fl_s4 <= '{degen: fl_s3.degen, colin: fl_s3.colin, dpos: fl_s3.dpos,
				cneg: cn[38]};
		end
	end

	// square root pipeline, index 0 is the shifted input
	logic                 sq_vld_s [0:NSQ];
	logic [63:0]          sq_v_s   [0:NSQ];
	logic [63:0]          sq_r_s   [0:NSQ];
	logic signed [XW-1:0] sq_x_s   [0:NSQ];
	flags_t               sq_fl_s  [0:NSQ];
	logic signed [63:0]   dext;

	assign dext = 64'(d_s4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) sq_vld_s[0] <= 1'b0;
		else if (en) sq_vld_s[0] <= vld_s4;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_v_s[0]  <= {16'b0, s2_s4} << {f_s4, 1'b0};
			sq_r_s[0]  <= '0;
			sq_x_s[0]  <= XW'(dext <<< f_s4);
			sq_fl_s[0] <= fl_s4;
		end
	end

	for (genvar k = 0; k < NSQ; k++) begin : g_sq
		localparam logic [64:0] BIT = 65'd1 << (62 - 2 * k);
		logic [64:0] t;
		assign t = {1'b0, sq_r_s[k]} + BIT;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) sq_vld_s[k+1] <= 1'b0;
			else if (en) sq_vld_s[k+1] <= sq_vld_s[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if ({1'b0, sq_v_s[k]} >= t) begin
					sq_v_s[k+1] <= sq_v_s[k] - t[63:0];
					sq_r_s[k+1] <= (sq_r_s[k] >> 1) + BIT[63:0];
				end else begin
					sq_v_s[k+1] <= sq_v_s[k];
					sq_r_s[k+1] <= sq_r_s[k] >> 1;
				end
				sq_x_s[k+1]  <= sq_x_s[k];
				sq_fl_s[k+1] <= sq_fl_s[k];
			end
		end
	end

	// CORDIC pipeline, index 0 is the quadrant fold
	logic                 cr_vld_s [0:NCR];
	logic signed [XW-1:0] cr_x_s   [0:NCR];
	logic signed [XW-1:0] cr_y_s   [0:NCR];
	logic signed [AW-1:0] cr_a_s   [0:NCR];
	flags_t               cr_fl_s  [0:NCR];
	logic signed [XW-1:0] sq_y;

	assign sq_y = XW'(sq_r_s[NSQ]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cr_vld_s[0] <= 1'b0;
		else if (en) cr_vld_s[0] <= sq_vld_s[NSQ];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (sq_x_s[NSQ] < 0) begin
				cr_x_s[0] <= sq_y;
				cr_y_s[0] <= -sq_x_s[NSQ];
				cr_a_s[0] <= AW'(36'd1 << 30);
			end else begin
				cr_x_s[0] <= sq_x_s[NSQ];
				cr_y_s[0] <= sq_y;
				cr_a_s[0] <= '0;
			end
			cr_fl_s[0] <= sq_fl_s[NSQ];
		end
	end

	for (genvar i = 0; i < NCR; i++) begin : g_cr
		logic signed [XW-1:0] xs, ys;
		logic signed [AW-1:0] at;
		assign xs = shr_sym(cr_x_s[i], 5'(i));
		assign ys = shr_sym(cr_y_s[i], 5'(i));
		assign at = $signed({4'b0, atan_lut(5'(i))});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) cr_vld_s[i+1] <= 1'b0;
			else if (en) cr_vld_s[i+1] <= cr_vld_s[i];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (cr_y_s[i] > 0) begin
					cr_x_s[i+1] <= cr_x_s[i] + ys;
					cr_y_s[i+1] <= cr_y_s[i] - xs;
					cr_a_s[i+1] <= cr_a_s[i] + at;
				end else begin
					cr_x_s[i+1] <= cr_x_s[i] - ys;
					cr_y_s[i+1] <= cr_y_s[i] + xs;
					cr_a_s[i+1] <= cr_a_s[i] - at;
				end
				cr_fl_s[i+1] <= cr_fl_s[i];
			end
		end
	end

	// output stage: round, orientation, special cases
	logic [AW-1:0] acc_u, acc_r;
	logic [AB:0]   theta, res;
	flags_t        fl_f;
	flags_t        fl_q;
	logic [AB:0]   ang_q;

	assign fl_f  = cr_fl_s[NCR];
	assign acc_u = cr_a_s[NCR][AW-1] ? '0 : $unsigned(cr_a_s[NCR]);
	assign acc_r = acc_u + AW'(1 << 15);
	assign theta = acc_r[AB+16:16];

	always_comb begin
		if (fl_f.degen) res = '0;
		else if (fl_f.colin) res = fl_f.dpos ? FULL_TURN : HALF_TURN;
		else if (fl_f.cneg) res = FULL_TURN - theta;
		else res = theta;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vout_q <= 1'b0;
		else if (en) vout_q <= cr_vld_s[NCR];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ang_q <= res;
			fl_q  <= fl_f;
		end
	end

	assign m_tvalid = vout_q;
	assign m_tdata  = {7'b0, ang_q};
	assign m_tuser  = fl_q.degen;

`ifndef SYNTHESIS
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[AB:0] == '0)
		else $error("degenerate item with non-zero angle");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[AB:0] <= FULL_TURN)
		else $error("angle beyond a full turn");

	a_colin: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] && fl_q.colin |->
		m_tdata[AB:0] == FULL_TURN || m_tdata[AB:0] == HALF_TURN)
		else $error("colinear item not a full or half turn");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(cr_vld_s[NCR]) && $stable(sq_vld_s[NSQ]))
		else $error("pipe moved during stall");
`endif

endmodule

FILE: dv/tb_signed_vector_angle_unit.sv
module tb_signed_vector_angle_unit
	import sva_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int LATENCY   = 71;
	localparam int WDOG_MAX  = 2000;

	typedef struct {
		logic [16:0] angle;
		logic        degen;
	} angle_res_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [111:0] s_tdata;   // a_x,a_y,a_z,b_x,b_y,b_z,n_x,n_y,n_z
	logic         m_tvalid;
	logic         m_tready;
	logic [23:0]  m_tdata;   // angle_turns, zero pad
	logic [0:0]   m_tuser;   // degenerate

	angle_res_t angle_q[$];
	int         n_err;
	int         idle_cnt;
	bit         send_gaps;
	bit         sink_gaps;
	bit         done;

	signed_vector_angle_unit i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	function automatic longint shr_mag(longint v, int n);
		if (v < 0) begin
			return -longint'(64'(-v) >> n);
		end
		return longint'(64'(v) >> n);
	endfunction

	function automatic longint unsigned root64(longint unsigned v);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) begin
			b >>= 2;
		end
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic angle_res_t predict_angle(logic [111:0] d);
		longint c[9];
		longint unsigned na2, nb2, s2, r2, acc, t;
		longint cx, cy, cz, dt, cn, x, y, xn, yn, accs;
		int f;
		angle_res_t r;
		for (int k = 0; k < 9; k++) begin
			c[k] = longint'($signed(d[k*12 +: 12]));
		end
		r.degen = 1'b0;
		na2 = c[0]*c[0] + c[1]*c[1] + c[2]*c[2];
		nb2 = c[3]*c[3] + c[4]*c[4] + c[5]*c[5];
		if (na2 == 0 || nb2 == 0) begin
			r.angle = '0;
			r.degen = 1'b1;
			return r;
		end
		cx = c[1]*c[5] - c[4]*c[2];
		cy = c[3]*c[2] - c[0]*c[5];
		cz = c[0]*c[4] - c[3]*c[1];
		dt = c[0]*c[3] + c[1]*c[4] + c[2]*c[5];
		if (cx == 0 && cy == 0 && cz == 0) begin
			r.angle = (dt > 0) ? FULL_TURN : HALF_TURN;
			return r;
		end
		s2 = cx*cx + cy*cy + cz*cz;
		r2 = na2 * nb2;
		f = 0;
		while (r2 < (64'd1 << 60)) begin
			r2 <<= 2;
			f++;
		end
		y = longint'(root64(s2 << (2*f)));
		x = dt * longint'(64'd1 << f);
		accs = 0;
		if (x < 0) begin
			xn = y;
			y = -x;
			x = xn;
			accs = longint'(64'd1 << 30);
		end
		for (int i = 0; i < 32; i++) begin
			if (y > 0) begin
				xn = x + shr_mag(y, i);
				yn = y - shr_mag(x, i);
				accs += longint'(atan_lut(5'(i)));
			end else begin
				xn = x - shr_mag(y, i);
				yn = y + shr_mag(x, i);
				accs -= longint'(atan_lut(5'(i)));
			end
			x = xn;
			y = yn;
		end
		acc = (accs < 0) ? 0 : $unsigned(accs);
		t = (acc + (64'd1 << 15)) >> 16;
		cn = cx*c[6] + cy*c[7] + cz*c[8];
		r.angle = 17'((cn < 0) ? (64'd65536 - t) : t);
		return r;
	endfunction

	task automatic send_item(input logic [111:0] d);
		int g;
		if (send_gaps && $urandom_range(3) == 0) begin
			g = $urandom_range(19, 1);
			s_tvalid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= d;
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
		angle_q.push_back(predict_angle(d));
		@(negedge clk);
	endtask

	function automatic logic [111:0] pack_vec(int v[9]);
		logic [111:0] d;
		d = '0;
		for (int k = 0; k < 9; k++) begin
			d[k*12 +: 12] = 12'(v[k]);
		end
		return d;
	endfunction

	function automatic int rnd_comp(int sz);
		return $signed(12'($urandom)) >>> sz;
	endfunction

	task automatic test_directed();
		int v[9];
		int ex[5] = '{-2048, 2047, 0, 1, -1};
		v = '{0, 0, 0, 5, 6, 7, 1, 1, 1};
		send_item(pack_vec(v));
		v = '{3, 4, 5, 0, 0, 0, 1, 1, 1};
		send_item(pack_vec(v));
		v = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
		send_item(pack_vec(v));
		v = '{2047, 2047, 2047, 2047, 2047, 2047, 2047, 2047, 2047};
		send_item(pack_vec(v));
		v = '{-2048, -2048, -2048, 2047, 2047, 2047, 1, 0, 0};
		send_item(pack_vec(v));
		v = '{1, 2, 3, -2, -4, -6, 0, 0, 0};
		send_item(pack_vec(v));
		v = '{1, 0, 0, 0, 1, 0, 0, 0, 1};
		send_item(pack_vec(v));
		v = '{1, 0, 0, 0, 1, 0, 0, 0, -1};
		send_item(pack_vec(v));
		v = '{1, 0, 0, 0, 1, 0, 1, 1, 0};
		send_item(pack_vec(v));
		v = '{2047, 0, 0, 2047, 1, 0, 0, 0, -2048};
		send_item(pack_vec(v));
		v = '{2047, 0, 0, -2048, 1, 0, 0, 0, 2047};
		send_item(pack_vec(v));
		v = '{-2048, 2047, -1, 1, -2048, 2047, -2048, -1, 2047};
		send_item(pack_vec(v));
		for (int k = 0; k < 9; k++) begin
			v[k] = ex[$urandom_range(4)];
		end
		send_item(pack_vec(v));
	endtask

	task automatic test_random(int n);
		int v[9];
		int sz;
		int kind;
		for (int j = 0; j < n; j++) begin
			sz = $urandom_range(10);
			for (int k = 0; k < 9; k++) begin
				v[k] = rnd_comp(sz);
			end
			kind = $urandom_range(9);
			if (kind == 0) begin
				sz = $urandom_range(4) - 2;
				for (int k = 0; k < 3; k++) begin
					v[k + 3] = v[k] * sz;
				end
			end else if (kind == 1) begin
				v[$urandom_range(1) * 3 + 0] = 0;
				v[1] = 0;
				v[2] = 0;
				v[4] = 0;
				v[5] = 0;
			end else if (kind == 2) begin
				v[3] = v[0] + $urandom_range(2) - 1;
				v[4] = v[1];
				v[5] = v[2];
			end
			send_item(pack_vec(v));
		end
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (angle_q.size() != 0) begin
			@(negedge clk);
		end
		repeat (LATENCY + 5) @(negedge clk);
	endtask

	always @(posedge clk) begin
		angle_res_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (angle_q.size() == 0) begin
				$error("unexpected item angle_turns=%0d", m_tdata[16:0]);
				n_err++;
			end else begin
				e = angle_q.pop_front();
				if (m_tdata[16:0] !== e.angle) begin
					$error("angle_turns exp %0d got %0d", e.angle, m_tdata[16:0]);
					n_err++;
				end
				if (m_tuser[0] !== e.degen) begin
					$error("degenerate exp %0d got %0d", e.degen, m_tuser[0]);
					n_err++;
				end
			end
		end
	end

	always begin
		int g;
		@(negedge clk);
		if (sink_gaps && $urandom_range(3) == 0) begin
			g = $urandom_range(19, 1);
			m_tready <= 1'b0;
			repeat (g) @(negedge clk);
		end
		m_tready <= 1'b1;
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || done
			|| (angle_q.size() == 0 && !s_tvalid)) begin
			idle_cnt <= 0;
		end else begin
			idle_cnt <= idle_cnt + 1;
		end
		if (idle_cnt >= WDOG_MAX) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		m_tready  = 1'b0;
		n_err     = 0;
		idle_cnt  = 0;
		done      = 1'b0;
		send_gaps = 1'b1;
		sink_gaps = 1'b1;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_random(200);
		// pause until the pipe is empty
		drain();
		test_random(150);
		send_gaps = 1'b0;
		sink_gaps = 1'b0;
		test_random(100);
		drain();
		done = 1'b1;
		if (n_err == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
